### sv/affinity_longest_queue_scheduler_core_macros.svh
// assertion helpers shared by the scheduler modules
// each expects clk and arst_n in scope
`ifndef AFFINITY_LONGEST_QUEUE_SCHEDULER_CORE_MACROS_SVH
`define AFFINITY_LONGEST_QUEUE_SCHEDULER_CORE_MACROS_SVH

// property that must hold at every clock edge outside reset
`define ALQS_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// same-cycle implication
`define ALQS_ASSERT_IMPLY(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define ALQS_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

### sv/alqs_pkg.sv
`default_nettype none

package alqs_pkg;

	// queue geometry
	localparam int QUEUE_DEPTH = 32;
	localparam int NUM_CLASSES = 4;
	localparam int CLASS_W     = 2;
	localparam int PTR_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int FILL_W      = $clog2(QUEUE_DEPTH + 1);
	localparam int STORE_DEPTH = NUM_CLASSES * QUEUE_DEPTH;
	localparam int ADDR_W      = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;

	// ticket sequence and field widths
	localparam int TICKET_BITS = 16;
	localparam int TICKET_W    = 16;
	localparam int COUNT_W     = 16;
	localparam int STATUS_W    = 3;

	// command queue between front and back end
	localparam int CMDQ_DEPTH  = 2;
	localparam int CMDQ_PTR_W  = (CMDQ_DEPTH > 1) ? $clog2(CMDQ_DEPTH) : 1;
	localparam int CMDQ_CNT_W  = $clog2(CMDQ_DEPTH + 1);

	typedef enum logic [1:0] {
		ACT_ISSUE = 2'd0,
		ACT_SERVE = 2'd1,
		ACT_STATS = 2'd2,
		ACT_NONE  = 2'd3
	} action_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_ISSUED   = 3'd0,
		ST_FULL     = 3'd1,
		ST_PRIMARY  = 3'd2,
		ST_FALLBACK = 3'd3,
		ST_IDLE     = 3'd4,
		ST_STATS    = 3'd5
	} status_t;

	typedef enum logic [1:0] {
		OP_NONE  = 2'd0,
		OP_WRITE = 2'd1,
		OP_READ  = 2'd2
	} op_t;

	// one classified word handed from front to back end
	typedef struct packed {
		op_t                    op;
		logic [ADDR_W-1:0]      addr;
		logic [TICKET_BITS-1:0] ticket;
		status_t                status;
		logic [CLASS_W-1:0]     cls;
		logic [COUNT_W-1:0]     pcount;
		logic [COUNT_W-1:0]     ocount;
	} cmd_t;

endpackage

`default_nettype wire

### sv/affinity_longest_queue_scheduler_core.sv
// result path: an accepted word moves from the command queue to the payload and result registers
// throughput: one item per cycle, the back end drains one command word a cycle
// busy follows the full flag of the two-word command queue, which one push and one pop
// a cycle never fill; the receiver cannot stall, so no word ever waits in the queue
// reset: asynchronous, clears queue pointers, fills and server counts, ticket sequence to one
`default_nettype none

`include "affinity_longest_queue_scheduler_core_macros.svh"

module affinity_longest_queue_scheduler_core
	import alqs_pkg::*;
(
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                start,
	output logic                     busy,
	input  wire logic [1:0]          action,
	input  wire logic [CLASS_W-1:0]  visa_class,
	input  wire logic [CLASS_W-1:0]  counter_id,
	output logic                     strobe,
	output logic [STATUS_W-1:0]      status,
	output logic [CLASS_W-1:0]       served_class,
	output logic [TICKET_W-1:0]      ticket,
	output logic [COUNT_W-1:0]       primary_count,
	output logic [COUNT_W-1:0]       other_count
);

	logic accept;
	logic full;
	logic not_empty;
	logic pop;
	cmd_t front_cmd;
	cmd_t head_cmd;

	assign busy   = full;
	assign accept = start && !full;

	// classify and update queue pointers
	alqs_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.action    (action),
		.visa_class(visa_class),
		.counter_id(counter_id),
		.cmd       (front_cmd)
	);

	// decoupling queue
	alqs_cmd_fifo u_cmdq (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (accept),
		.push_cmd (front_cmd),
		.pop      (pop),
		.head     (head_cmd),
		.not_empty(not_empty),
		.full     (full)
	);

	// ticket store access and result word
	alqs_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd_valid    (not_empty),
		.cmd          (head_cmd),
		.pop          (pop),
		.strobe       (strobe),
		.status       (status),
		.served_class (served_class),
		.ticket       (ticket),
		.primary_count(primary_count),
		.other_count  (other_count)
	);

	`ALQS_ASSERT_IMPLY(a_stats_clean, strobe && (status == ST_STATS),
		(ticket == '0) && (served_class == '0), "stats word carries a ticket")

endmodule

`default_nettype wire

### sv/alqs_ram.sv
`default_nettype none

module alqs_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 128
) (
	input  wire logic                                     clk,
	input  wire logic                                     we,
	input  wire logic                                     re,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] addr,
	input  wire logic [WIDTH-1:0]                         wdata,
	output logic      [WIDTH-1:0]                         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// single port, registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[addr];
		end
	end

endmodule

`default_nettype wire

### sv/alqs_front.sv
`default_nettype none

module alqs_front
	import alqs_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               accept,
	input  wire logic [1:0]         action,
	input  wire logic [CLASS_W-1:0] visa_class,
	input  wire logic [CLASS_W-1:0] counter_id,
	output cmd_t                    cmd
);

	localparam int SUM_W = FILL_W + 1;

	logic [FILL_W-1:0]      fill_q [NUM_CLASSES];
	logic [PTR_W-1:0]       head_q [NUM_CLASSES];
	logic [COUNT_W-1:0]     prim_q [NUM_CLASSES];
	logic [COUNT_W-1:0]     fall_q [NUM_CLASSES];
	logic [TICKET_BITS-1:0] next_q;

	logic [FILL_W-1:0]      fill_d [NUM_CLASSES];
	logic [PTR_W-1:0]       head_d [NUM_CLASSES];
	logic [COUNT_W-1:0]     prim_d [NUM_CLASSES];
	logic [COUNT_W-1:0]     fall_d [NUM_CLASSES];
	logic [TICKET_BITS-1:0] next_d;

	logic [CLASS_W-1:0]     best_cls;
	logic [CLASS_W-1:0]     pop_cls;
	logic                   pop_en;
	logic [SUM_W-1:0]       tail_sum;
	logic [PTR_W-1:0]       tail_pos;

	// longest queue, ties to the lowest class
	always_comb begin
		best_cls = '0;
		for (int c = 1; c < NUM_CLASSES; c++) begin
			if (fill_q[c] > fill_q[best_cls]) begin
				best_cls = CLASS_W'(c);
			end
		end
	end

	// ring position of the tail of the issue class
	always_comb begin
		tail_sum = SUM_W'(head_q[visa_class]) + SUM_W'(fill_q[visa_class]);
		if (tail_sum >= SUM_W'(QUEUE_DEPTH)) begin
			tail_sum = tail_sum - SUM_W'(QUEUE_DEPTH);
		end
		tail_pos = PTR_W'(tail_sum);
	end

	// classify the item and work out the next pointer state
	always_comb begin
		fill_d = fill_q;
		head_d = head_q;
		prim_d = prim_q;
		fall_d = fall_q;
		next_d = next_q;
		pop_cls = counter_id;
		pop_en = 1'b0;
		cmd = '0;
		cmd.op = OP_NONE;
		cmd.status = ST_IDLE;
		case (action_t'(action))
			ACT_ISSUE: begin
				cmd.cls = visa_class;
				if (fill_q[visa_class] < FILL_W'(QUEUE_DEPTH)) begin
					cmd.op = OP_WRITE;
					cmd.status = ST_ISSUED;
					cmd.ticket = next_q;
					cmd.addr = ADDR_W'(visa_class) * ADDR_W'(QUEUE_DEPTH) + ADDR_W'(tail_pos);
					fill_d[visa_class] = fill_q[visa_class] + 1'b1;
					next_d = next_q + 1'b1;
				end else begin
					cmd.status = ST_FULL;
				end
			end
			ACT_SERVE: begin
				if (fill_q[counter_id] != '0) begin
					pop_en = 1'b1;
					pop_cls = counter_id;
					cmd.status = ST_PRIMARY;
					prim_d[counter_id] = prim_q[counter_id] + 1'b1;
				end else if (fill_q[best_cls] != '0) begin
					pop_en = 1'b1;
					pop_cls = best_cls;
					cmd.status = ST_FALLBACK;
					fall_d[counter_id] = fall_q[counter_id] + 1'b1;
				end
			end
			ACT_STATS: begin
				cmd.status = ST_STATS;
				cmd.pcount = prim_q[counter_id];
				cmd.ocount = fall_q[counter_id];
			end
			default: begin
				cmd.status = ST_IDLE;
			end
		endcase
		// pop from the head of the chosen class
		if (pop_en) begin
			cmd.op = OP_READ;
			cmd.cls = pop_cls;
			cmd.addr = ADDR_W'(pop_cls) * ADDR_W'(QUEUE_DEPTH) + ADDR_W'(head_q[pop_cls]);
			fill_d[pop_cls] = fill_q[pop_cls] - 1'b1;
			head_d[pop_cls] = (head_q[pop_cls] == PTR_W'(QUEUE_DEPTH - 1)) ? '0
				: head_q[pop_cls] + 1'b1;
		end
	end

	// queue pointers, ticket sequence and server counts
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int c = 0; c < NUM_CLASSES; c++) begin
				fill_q[c] <= '0;
				head_q[c] <= '0;
				prim_q[c] <= '0;
				fall_q[c] <= '0;
			end
			next_q <= TICKET_BITS'(1);
		end else if (accept) begin
			fill_q <= fill_d;
			head_q <= head_d;
			prim_q <= prim_d;
			fall_q <= fall_d;
			next_q <= next_d;
		end
	end

endmodule

`default_nettype wire

### sv/alqs_cmd_fifo.sv
`default_nettype none

`include "affinity_longest_queue_scheduler_core_macros.svh"

module alqs_cmd_fifo
	import alqs_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic push,
	input  cmd_t      push_cmd,
	input  wire logic pop,
	output cmd_t      head,
	output logic      not_empty,
	output logic      full
);

	cmd_t                  entry_q [CMDQ_DEPTH];
	logic [CMDQ_PTR_W-1:0] wr_ptr_q;
	logic [CMDQ_PTR_W-1:0] rd_ptr_q;
	logic [CMDQ_CNT_W-1:0] count_q;

	assign head      = entry_q[rd_ptr_q];
	assign not_empty = (count_q != '0);
	assign full      = (count_q == CMDQ_CNT_W'(CMDQ_DEPTH));

	// word storage
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_cmd;
		end
	end

	// pointers and fill
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == CMDQ_PTR_W'(CMDQ_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == CMDQ_PTR_W'(CMDQ_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	`ALQS_ASSERT_IMPLY(a_no_push_full, push, !full, "command queue written while full")

endmodule

`default_nettype wire

### sv/alqs_back.sv
`default_nettype none

`include "affinity_longest_queue_scheduler_core_macros.svh"

module alqs_back
	import alqs_pkg::*;
(
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                cmd_valid,
	input  cmd_t                     cmd,
	output logic                     pop,
	output logic                     strobe,
	output logic [STATUS_W-1:0]      status,
	output logic [CLASS_W-1:0]       served_class,
	output logic [TICKET_W-1:0]      ticket,
	output logic [COUNT_W-1:0]       primary_count,
	output logic [COUNT_W-1:0]       other_count
);

	logic [TICKET_BITS-1:0] rdata;
	logic                   valid_s1;
	cmd_t                   cmd_s1;
	logic                   strobe_s2;
	status_t                status_s2;
	logic [CLASS_W-1:0]     cls_s2;
	logic [TICKET_W-1:0]    ticket_s2;
	logic [COUNT_W-1:0]     pcount_s2;
	logic [COUNT_W-1:0]     ocount_s2;

	// the back end drains one word a cycle
	assign pop = cmd_valid;

	// ticket store access
	alqs_ram #(
		.WIDTH(TICKET_BITS),
		.DEPTH(STORE_DEPTH)
	) u_store (
		.clk  (clk),
		.we   (cmd_valid && (cmd.op == OP_WRITE)),
		.re   (cmd_valid && (cmd.op == OP_READ)),
		.addr (cmd.addr),
		.wdata(cmd.ticket),
		.rdata(rdata)
	);

	// stage 1 control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= cmd_valid;
		end
	end

	// stage 1 payload
	always_ff @(posedge clk) begin
		if (cmd_valid) begin
			cmd_s1 <= cmd;
		end
	end

	// result strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strobe_s2 <= 1'b0;
		end else begin
			strobe_s2 <= valid_s1;
		end
	end

	// result word, served ticket taken from the store
	always_ff @(posedge clk) begin
		if (valid_s1) begin
			status_s2 <= cmd_s1.status;
			cls_s2    <= cmd_s1.cls;
			pcount_s2 <= cmd_s1.pcount;
			ocount_s2 <= cmd_s1.ocount;
			ticket_s2 <= (cmd_s1.op == OP_READ) ? TICKET_W'(rdata) : TICKET_W'(cmd_s1.ticket);
		end
	end

	assign strobe        = strobe_s2;
	assign status        = status_s2;
	assign served_class  = cls_s2;
	assign ticket        = ticket_s2;
	assign primary_count = pcount_s2;
	assign other_count   = ocount_s2;

	`ALQS_ASSERT_NEXT(a_s1_to_result, valid_s1, strobe_s2, "stage 1 word lost before result")
	`ALQS_ASSERT_IMPLY(a_write_is_issue, valid_s1 && (cmd_s1.op == OP_WRITE),
		cmd_s1.status == ST_ISSUED, "store write without an issued ticket")

endmodule

`default_nettype wire

### bench/tb_affinity_longest_queue_scheduler_core.sv
`default_nettype none

module tb_affinity_longest_queue_scheduler_core;
	timeunit 1ns;
	timeprecision 1ps;

	import alqs_pkg::*;

	// one command word waiting to be driven
	typedef struct {
		action_t    act;
		logic [1:0] cls;
		logic [1:0] srv;
		bit         hurry;
	} sched_item_t;

	// one answer word as the scheduler should give it
	typedef struct packed {
		status_t             st;
		logic [CLASS_W-1:0]  cls;
		logic [TICKET_W-1:0] tk;
		logic [COUNT_W-1:0]  pc;
		logic [COUNT_W-1:0]  oc;
	} sched_word_t;

	logic                clk;
	logic                arst_n = 1'b0;
	logic                start = 1'b0;
	logic [1:0]          action = 2'd0;
	logic [CLASS_W-1:0]  visa_class = '0;
	logic [CLASS_W-1:0]  counter_id = '0;
	logic                busy;
	logic                strobe;
	logic [STATUS_W-1:0] status;
	logic [CLASS_W-1:0]  served_class;
	logic [TICKET_W-1:0] ticket;
	logic [COUNT_W-1:0]  primary_count;
	logic [COUNT_W-1:0]  other_count;

	affinity_longest_queue_scheduler_core uut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.action(action),
		.visa_class(visa_class),
		.counter_id(counter_id),
		.strobe(strobe),
		.status(status),
		.served_class(served_class),
		.ticket(ticket),
		.primary_count(primary_count),
		.other_count(other_count)
	);

	// mirror of the scheduler state
	logic [TICKET_BITS-1:0] ring [NUM_CLASSES][QUEUE_DEPTH];
	logic [PTR_W-1:0]       head [NUM_CLASSES];
	logic [FILL_W-1:0]      fill [NUM_CLASSES];
	logic [TICKET_BITS-1:0] next_tk;
	logic [COUNT_W-1:0]     prim_serves [NUM_CLASSES];
	logic [COUNT_W-1:0]     fall_serves [NUM_CLASSES];

	sched_item_t pending[$];
	sched_word_t due_words[$];

	int items_total;
	int items_taken;
	int fault_count;
	int reported;
	int tk_wraps;
	int seen_by_status [6];
	int gap_left;
	int calm_left;
	bit took_last;

	// clock
	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// pop the oldest ticket of one class
	function automatic logic [TICKET_BITS-1:0] take_head(logic [1:0] c);
		logic [TICKET_BITS-1:0] t;
		t = ring[c][head[c]];
		if (head[c] == PTR_W'(QUEUE_DEPTH - 1))
			head[c] = '0;
		else
			head[c] = head[c] + 1'b1;
		fill[c] = fill[c] - 1'b1;
		return t;
	endfunction

	// work out the answer word for one accepted command and update the mirror
	function automatic sched_word_t schedule_step(action_t act, logic [1:0] cls,
			logic [1:0] srv);
		sched_word_t w;
		logic [1:0]  pick;
		int          slot;
		w = '0;
		w.st = ST_IDLE;
		case (act)
			ACT_ISSUE: begin
				w.cls = cls;
				if (fill[cls] < QUEUE_DEPTH) begin
					slot = int'(head[cls]) + int'(fill[cls]);
					if (slot >= QUEUE_DEPTH)
						slot -= QUEUE_DEPTH;
					ring[cls][slot] = next_tk;
					w.tk = TICKET_W'(next_tk);
					w.st = ST_ISSUED;
					fill[cls] = fill[cls] + 1'b1;
					next_tk = next_tk + 1'b1;
					if (next_tk == '0)
						tk_wraps++;
				end else begin
					w.st = ST_FULL;
				end
			end
			ACT_SERVE: begin
				if (fill[srv] != 0) begin
					w.cls = srv;
					w.tk = TICKET_W'(take_head(srv));
					w.st = ST_PRIMARY;
					prim_serves[srv] = prim_serves[srv] + 1'b1;
				end else begin
					// longest queue, lowest class on a tie
					pick = 2'd0;
					for (int c = 1; c < NUM_CLASSES; c++)
						if (fill[c] > fill[pick])
							pick = 2'(c);
					if (fill[pick] != 0) begin
						w.cls = pick;
						w.tk = TICKET_W'(take_head(pick));
						w.st = ST_FALLBACK;
						fall_serves[srv] = fall_serves[srv] + 1'b1;
					end
				end
			end
			ACT_STATS: begin
				w.st = ST_STATS;
				w.pc = prim_serves[srv];
				w.oc = fall_serves[srv];
			end
			default: ;
		endcase
		return w;
	endfunction

	task automatic queue_item(action_t a, int c, int s, bit hurry = 1'b0);
		sched_item_t it;
		it.act = a;
		it.cls = 2'(c);
		it.srv = 2'(s);
		it.hurry = hurry;
		pending.push_back(it);
	endtask

	// command driver, changes inputs on the falling edge
	always @(negedge clk) begin : feed
		sched_item_t it;
		int          r;
		if (!arst_n) begin
			start <= 1'b0;
		end else if (start && !took_last) begin
			// word still waiting to be taken
		end else if (gap_left != 0) begin
			start <= 1'b0;
			gap_left <= gap_left - 1;
		end else if (pending.size() != 0) begin
			it = pending.pop_front();
			action <= it.act;
			visa_class <= it.cls;
			counter_id <= it.srv;
			start <= 1'b1;
			if (it.hurry) begin
				gap_left <= 0;
			end else if (calm_left != 0) begin
				gap_left <= 0;
				calm_left <= calm_left - 1;
			end else begin
				// mostly short gaps, a few long, now and then a run with none
				r = $urandom_range(0, 99);
				if (r < 3)
					calm_left <= $urandom_range(20, 80);
				if (r < 55)
					gap_left <= 0;
				else if (r < 85)
					gap_left <= $urandom_range(1, 3);
				else if (r < 96)
					gap_left <= $urandom_range(4, 12);
				else
					gap_left <= $urandom_range(20, 60);
			end
		end else begin
			start <= 1'b0;
		end
	end

	// answer checker and command capture on the rising edge
	always @(posedge clk) begin : watch
		sched_word_t want;
		if (arst_n) begin
			if (strobe) begin
				if (due_words.size() == 0) begin
					fault_count++;
					if (reported < 10)
						$display("answer word with nothing due: st=%0d cls=%0d tk=%0d",
							status, served_class, ticket);
					reported++;
				end else begin
					want = due_words.pop_front();
					seen_by_status[int'(want.st)]++;
					if (status !== want.st || served_class !== want.cls || ticket !== want.tk
							|| primary_count !== want.pc || other_count !== want.oc) begin
						fault_count++;
						if (reported < 10) begin
							$display("mismatch: want st=%0d cls=%0d tk=%0d pc=%0d oc=%0d",
								want.st, want.cls, want.tk, want.pc, want.oc);
							$display("          got  st=%0d cls=%0d tk=%0d pc=%0d oc=%0d",
								status, served_class, ticket, primary_count, other_count);
						end
						reported++;
					end
				end
			end
			if (start && !busy) begin
				due_words.push_back(schedule_step(action_t'(action), visa_class, counter_id));
				items_taken++;
			end
		end
		took_last <= arst_n && start && !busy;
	end

	// run limit
	initial begin
		#4000000;
		$display("CHECKS FAILED");
		$finish;
	end

	initial begin : stimulus
		int rand_items;
		int kind;
		int n;
		int c;
		int s;
		int wait_cycles;

		for (int k = 0; k < NUM_CLASSES; k++) begin
			head[k] = '0;
			fill[k] = '0;
			prim_serves[k] = '0;
			fall_serves[k] = '0;
		end
		next_tk = TICKET_BITS'(1);

		// directed: empty serve, zero stats, unused code, affinity, fallback and tie
		queue_item(ACT_SERVE, 0, 0);
		queue_item(ACT_STATS, 0, 3);
		queue_item(ACT_NONE, 3, 3);
		queue_item(ACT_ISSUE, 0, 0);
		queue_item(ACT_ISSUE, 1, 0);
		queue_item(ACT_ISSUE, 2, 0);
		queue_item(ACT_ISSUE, 3, 0);
		queue_item(ACT_ISSUE, 2, 0);
		queue_item(ACT_SERVE, 0, 3);
		queue_item(ACT_SERVE, 0, 1);
		queue_item(ACT_SERVE, 0, 3);
		queue_item(ACT_SERVE, 0, 1);
		queue_item(ACT_SERVE, 0, 2);
		queue_item(ACT_SERVE, 3, 3);
		for (int k = 0; k < NUM_CLASSES; k++)
			queue_item(ACT_STATS, 0, k);
		queue_item(ACT_NONE, 0, 2);
		queue_item(ACT_ISSUE, 3, 1);
		queue_item(ACT_STATS, 2, 3);

		// back-to-back issue and serve pairs
		for (int k = 0; k < 40; k++) begin
			queue_item(ACT_ISSUE, 0, $urandom_range(0, 3), 1'b1);
			queue_item(ACT_SERVE, $urandom_range(0, 3), 0, 1'b1);
		end

		// random sequences: floods towards full, drains into fallback, mixed and stats
		rand_items = 0;
		while (rand_items < 540) begin
			kind = $urandom_range(0, 99);
			if (kind < 30) begin
				c = $urandom_range(0, 3);
				n = $urandom_range(4, 40);
				for (int k = 0; k < n; k++)
					if ($urandom_range(0, 9) == 0)
						queue_item(ACT_STATS, $urandom_range(0, 3), $urandom_range(0, 3));
					else
						queue_item(ACT_ISSUE, c, $urandom_range(0, 3));
				rand_items += n;
			end else if (kind < 60) begin
				s = $urandom_range(0, 3);
				n = $urandom_range(4, 30);
				for (int k = 0; k < n; k++)
					queue_item(ACT_SERVE, $urandom_range(0, 3),
						($urandom_range(0, 3) == 0) ? $urandom_range(0, 3) : s);
				rand_items += n;
			end else if (kind < 90) begin
				n = $urandom_range(5, 20);
				for (int k = 0; k < n; k++) begin
					if ($urandom_range(0, 15) == 0)
						queue_item(ACT_NONE, $urandom_range(0, 3), $urandom_range(0, 3));
					queue_item(action_t'($urandom_range(0, 2)), $urandom_range(0, 3),
						$urandom_range(0, 3));
				end
				rand_items += n;
			end else begin
				for (int k = 0; k < NUM_CLASSES; k++)
					queue_item(ACT_STATS, $urandom_range(0, 3), k);
				rand_items += NUM_CLASSES;
			end
		end
		items_total = pending.size();

		// reset, then let the driver run
		repeat (9) @(negedge clk);
		arst_n = 1'b1;

		while (items_taken != items_total)
			@(negedge clk);
		wait_cycles = 0;
		while (due_words.size() != 0 && wait_cycles < 200) begin
			@(negedge clk);
			wait_cycles++;
		end
		repeat (12) @(negedge clk);

		if (due_words.size() != 0) begin
			fault_count += due_words.size();
			$display("%0d answer words never arrived", due_words.size());
		end

		$display("%0d command words: %0d issued, %0d full, %0d primary, %0d fallback",
			items_total, seen_by_status[ST_ISSUED], seen_by_status[ST_FULL],
			seen_by_status[ST_PRIMARY], seen_by_status[ST_FALLBACK]);
		$display("%0d idle, %0d stats reads, ticket sequence wrapped %0d times, %0d faults",
			seen_by_status[ST_IDLE], seen_by_status[ST_STATS], tk_wraps, fault_count);
		if (fault_count == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule

`default_nettype wire
